// ===== src/grid_line_of_sight_trace_core_assert.svh =====
// Assertion macros shared by the line-of-sight tracer modules.
`ifndef GRID_LINE_OF_SIGHT_TRACE_CORE_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_TRACE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GLOS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GLOS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/glos_pkg.sv =====
// Types and constants shared by the line-of-sight tracer modules.
package glos_pkg;

  localparam int ROW_W = 6;
  localparam int COL_W = 8;
  localparam int FRAC_W = 19;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             value;
  } map_wr_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } map_rd_t;

endpackage

// ===== src/grid_line_of_sight_trace_core.sv =====
// Line-of-sight tracer over a grid map of blocking cells: control, walk and output.
//
//   Channel  Dir  Moves                          Accepted when
//   s_*      in   map write or line query item   s_tvalid && s_tready
//   m_*      out  line_clear result item         m_tvalid && m_tready
//
// A write gives no result. A query goes through the setup states SETUP, MUL and PREP after
// it is accepted, then WALK reads each cell checked on the line (main and side cells) from
// the map's single read port, and DONE loads the result. Equal or adjacent endpoints skip the
// walk, and a blocked cell ends the walk once its registered read data comes back. After reset
// a clearing pass over all MAP_ROWS rows runs, one map row per cycle, with s_tready low. The
// result waits in an output register, so the next item is taken while it waits; a query's end
// stalls only while an earlier result is still held.
`include "grid_line_of_sight_trace_core_assert.svh"

module grid_line_of_sight_trace_core #(
  parameter int MAP_ROWS = 64,
  parameter int MAP_COLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // map_row[5:0], map_col[13:6], map_blocks[14], start_row[20:15], start_col[28:21],
  // end_row[34:29], end_col[42:35], zeros[47:43]
  input  logic [47:0] s_tdata,
  // req_type[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // line_clear[0], zeros[7:1]
  output logic [7:0]  m_tdata
);

  localparam int ROW_W = glos_pkg::ROW_W;
  localparam int COL_W = glos_pkg::COL_W;
  localparam int FRAC_W = glos_pkg::FRAC_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_PREP  = 6'b001000,
    ST_WALK  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;

  glos_pkg::map_wr_t wr;
  glos_pkg::map_rd_t rd;
  logic              rd_bit;
  logic              map_busy;

  logic [ROW_W-1:0] q_sr;
  logic [COL_W-1:0] q_sc;
  logic [ROW_W-1:0] q_er;
  logic [COL_W-1:0] q_ec;

  logic [COL_W-1:0] am;
  logic [COL_W-1:0] an;
  logic [COL_W-1:0] maj;
  logic [COL_W-1:0] min;
  logic [COL_W-1:0] n;
  logic             rows_major;
  logic             smaj_neg;
  logic             smin_neg;
  logic             smin_zero;
  logic             knight;
  logic             side_phase;
  logic             gen_done;
  logic             rd_pend;
  logic             res_clear;
  logic             out_clear;

  logic signed [FRAC_W-1:0] half;
  logic signed [FRAC_W-1:0] frac;
  logic signed [FRAC_W-1:0] slope;
  logic signed [FRAC_W-1:0] slope_m_full;

  logic signed [ROW_W:0]    dr;
  logic signed [COL_W:0]    dc;
  logic [ROW_W-1:0]         ar;
  logic [COL_W-1:0]         ac;
  logic                     near;
  logic                     cols_ge;
  logic signed [FRAC_W-1:0] fs;
  logic signed [FRAC_W-1:0] fs_m_full;
  logic [COL_W-1:0]         maj_step;
  logic [COL_W-1:0]         min_step;
  logic [COL_W-1:0]         n_inc;
  logic                     gen_active;
  logic                     s_acc;
  logic                     out_load;

  assign s_tready = (state == ST_IDLE) && !map_busy;
  assign s_acc    = s_tvalid && s_tready;

  assign wr.en    = s_acc && (s_tuser == glos_pkg::REQ_WRITE);
  assign wr.row   = s_tdata[5:0];
  assign wr.col   = s_tdata[13:6];
  assign wr.value = s_tdata[14];

  assign dr      = $signed({1'b0, q_er}) - $signed({1'b0, q_sr});
  assign dc      = $signed({1'b0, q_ec}) - $signed({1'b0, q_sc});
  assign ar      = dr[ROW_W] ? ROW_W'(-dr) : ROW_W'(dr);
  assign ac      = dc[COL_W] ? COL_W'(-dc) : COL_W'(dc);
  assign near    = (ar < ROW_W'(2)) && (ac < COL_W'(2));
  assign cols_ge = ac >= COL_W'(ar);

  assign fs        = frac + slope;
  assign fs_m_full = frac + slope_m_full;
  assign maj_step  = smaj_neg ? maj - COL_W'(1) : maj + COL_W'(1);
  assign min_step  = smin_zero ? min : (smin_neg ? min - COL_W'(1) : min + COL_W'(1));
  assign n_inc     = n + COL_W'(1);

  assign gen_active = (state == ST_WALK) && !gen_done;
  assign rd.en      = gen_active;
  assign rd.row     = rows_major ? ROW_W'(maj) : ROW_W'(min);
  assign rd.col     = rows_major ? min : maj;

  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      gen_done <= 1'b1;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= gen_active;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc && (s_tuser == glos_pkg::REQ_QUERY)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state <= near ? ST_DONE : ST_MUL;
        end
        ST_MUL: begin
          state <= ST_PREP;
        end
        ST_PREP: begin
          state    <= ST_WALK;
          gen_done <= 1'b0;
        end
        ST_WALK: begin
          if (rd_pend && rd_bit) begin
            state    <= ST_DONE;
            gen_done <= 1'b1;
          end else if (gen_done && !rd_pend) begin
            state <= ST_DONE;
          end else if (gen_active) begin
            if (side_phase) begin
              gen_done <= n_inc == am;
            end else if (knight) begin
              gen_done <= 1'b1;
            end else if (fs <= half) begin
              gen_done <= n_inc == am;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      q_sr <= s_tdata[20:15];
      q_sc <= s_tdata[28:21];
      q_er <= s_tdata[34:29];
      q_ec <= s_tdata[42:35];
    end
    if (out_load) begin
      out_clear <= res_clear;
    end
    case (state)
      ST_SETUP: begin
        rows_major <= !cols_ge;
        am         <= cols_ge ? ac : COL_W'(ar);
        an         <= cols_ge ? COL_W'(ar) : ac;
        maj        <= cols_ge ? q_sc : COL_W'(q_sr);
        min        <= cols_ge ? COL_W'(q_sr) : q_sc;
        smaj_neg   <= cols_ge ? dc[COL_W] : dr[ROW_W];
        smin_neg   <= cols_ge ? dr[ROW_W] : dc[COL_W];
        smin_zero  <= (ar == '0) || (ac == '0);
        knight     <= ((ac == COL_W'(1)) && (ar == ROW_W'(2))) ||
                      ((ar == ROW_W'(1)) && (ac == COL_W'(2)));
        res_clear  <= 1'b1;
      end
      ST_MUL: begin
        half <= FRAC_W'({8'b0, am} * {8'b0, an});
        frac <= FRAC_W'({8'b0, an} * {8'b0, an});
      end
      ST_PREP: begin
        slope        <= frac <<< 1;
        slope_m_full <= (frac <<< 1) - (half <<< 1);
        maj          <= maj_step;
        n            <= COL_W'(1);
        side_phase   <= 1'b0;
        if (frac == half) begin
          min  <= min_step;
          frac <= frac - (half <<< 1);
        end
      end
      ST_WALK: begin
        if (rd_pend && rd_bit) begin
          res_clear <= 1'b0;
        end
        if (gen_active) begin
          if (side_phase) begin
            maj        <= maj_step;
            n          <= n_inc;
            side_phase <= 1'b0;
          end else if (fs > half) begin
            min        <= min_step;
            frac       <= fs_m_full;
            side_phase <= 1'b1;
          end else begin
            if (fs == half) begin
              min  <= min_step;
              frac <= fs_m_full;
            end else begin
              frac <= fs;
            end
            maj <= maj_step;
            n   <= n_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {7'b0, out_clear};

  glos_map #(
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .rd    (rd),
    .rd_bit(rd_bit),
    .busy  (map_busy)
  );

  `GLOS_ASSERT_SAME(a_load_free, clk, rst, out_load, !m_tvalid || m_tready,
                    "result loaded over a held result")
  `GLOS_ASSERT_SAME(a_read_in_walk, clk, rst, rd.en, state == ST_WALK, "map read outside walk")
  `GLOS_ASSERT_NEXT(a_block_ends, clk, rst, (state == ST_WALK) && rd_pend && rd_bit,
                    (state == ST_DONE) && !res_clear, "blocked cell did not end the query")

endmodule

// ===== src/glos_map.sv =====
// Blocking-cell map memory with row-wide storage, clearing pass and one read port.
`include "grid_line_of_sight_trace_core_assert.svh"

module glos_map #(
  parameter int MAP_ROWS = 64,
  parameter int MAP_COLS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  glos_pkg::map_wr_t wr,
  input  glos_pkg::map_rd_t rd,
  output logic              rd_bit,
  output logic              busy
);

  localparam int RA_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int CA_W = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam logic [RA_W-1:0] LAST_ROW = RA_W'(MAP_ROWS - 1);

  logic [MAP_COLS-1:0] mem [MAP_ROWS];

  logic            clr_busy;
  logic [RA_W-1:0] clr_row;

  logic [RA_W-1:0]     wr_ra;
  logic [CA_W-1:0]     wr_ca;
  logic                wr_in;
  logic [RA_W-1:0]     rd_ra;
  logic [CA_W-1:0]     rd_ca;
  logic                rd_in;
  logic [MAP_COLS-1:0] rd_data;
  logic [CA_W-1:0]     rd_ca_q;
  logic                rd_in_q;

  assign wr_ra = RA_W'(wr.row);
  assign wr_ca = CA_W'(wr.col);
  assign wr_in = (int'(wr.row) < MAP_ROWS) && (int'(wr.col) < MAP_COLS);
  assign rd_ra = RA_W'(rd.row);
  assign rd_ca = CA_W'(rd.col);
  assign rd_in = (int'(rd.row) < MAP_ROWS) && (int'(rd.col) < MAP_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      if (clr_row == LAST_ROW) begin
        clr_busy <= 1'b0;
      end
      clr_row <= clr_row + RA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_row] <= '0;
    end else if (wr.en && wr_in) begin
      mem[wr_ra][wr_ca] <= wr.value;
    end
    if (rd.en) begin
      rd_data <= mem[rd_ra];
      rd_ca_q <= rd_ca;
      rd_in_q <= rd_in;
    end
  end

  assign rd_bit = rd_in_q & rd_data[rd_ca_q];
  assign busy   = clr_busy;

  `GLOS_ASSERT_SAME(a_no_write_in_clear, clk, rst, wr.en, !clr_busy, "map write during clear")
  `GLOS_ASSERT_SAME(a_no_read_in_clear, clk, rst, rd.en, !clr_busy, "map read during clear")
  `GLOS_ASSERT_NEXT(a_clear_runs, clk, rst, clr_busy && (clr_row != LAST_ROW), clr_busy,
                    "clearing pass ended early")

endmodule

// ===== tb/grid_line_of_sight_trace_core_tb.sv =====
// Testbench for the line-of-sight tracer: map writes and line queries checked against a predictor.
`timescale 1ns / 1ps

module grid_line_of_sight_trace_core_tb;

  localparam int MAP_ROWS = 64;
  localparam int MAP_COLS = 256;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 400;

  class los_tracker;
    bit [MAP_COLS-1:0] wall_map [MAP_ROWS];
    bit                clear_answers [$];
    int                failures;

    function new();
      foreach (wall_map[r]) wall_map[r] = '0;
      failures = 0;
    endfunction

    function bit wall_at(int r, int c);
      if (r < 0 || r >= MAP_ROWS || c < 0 || c >= MAP_COLS) return 1'b0;
      return wall_map[r][c];
    endfunction

    function bit axis_wall(int maj, int mnr, bit rows_major);
      return rows_major ? wall_at(maj, mnr) : wall_at(mnr, maj);
    endfunction

    function bit walk_is_clear(int maj0, int mnr0, int smaj, int smnr, int am, int an,
                               bit rows_major);
      int half;
      int full;
      int frac;
      int slope;
      int maj;
      int mnr;
      half  = am * an;
      full  = half * 2;
      frac  = an * an;
      slope = frac * 2;
      maj   = maj0 + smaj;
      mnr   = mnr0;
      if (frac == half) begin
        mnr  = mnr0 + smnr;
        frac = frac - full;
      end
      for (int n = 1; n < am; n++) begin
        if (axis_wall(maj, mnr, rows_major)) return 1'b0;
        frac = frac + slope;
        if (frac > half) begin
          mnr = mnr + smnr;
          if (axis_wall(maj, mnr, rows_major)) return 1'b0;
          frac = frac - full;
        end else if (frac == half) begin
          mnr  = mnr + smnr;
          frac = frac - full;
        end
        maj = maj + smaj;
      end
      return 1'b1;
    endfunction

    function bit line_is_clear(int r1, int c1, int r2, int c2);
      int dr;
      int dc;
      int ar;
      int ac;
      int sr;
      int sc;
      dr = r2 - r1;
      dc = c2 - c1;
      ar = dr < 0 ? -dr : dr;
      ac = dc < 0 ? -dc : dc;
      sr = dr < 0 ? -1 : 1;
      sc = dc < 0 ? -1 : 1;
      if (ar < 2 && ac < 2) return 1'b1;
      if (dc == 0) begin
        for (int k = 1; k < ar; k++)
          if (wall_at(r1 + sr * k, c1)) return 1'b0;
        return 1'b1;
      end
      if (dr == 0) begin
        for (int k = 1; k < ac; k++)
          if (wall_at(r1, c1 + sc * k)) return 1'b0;
        return 1'b1;
      end
      if (ac == 1) begin
        if (ar == 2 && !wall_at(r1 + sr, c1)) return 1'b1;
      end else if (ar == 1) begin
        if (ac == 2 && !wall_at(r1, c1 + sc)) return 1'b1;
      end
      if (ac >= ar) return walk_is_clear(c1, r1, sc, sr, ac, ar, 1'b0);
      return walk_is_clear(r1, c1, sr, sc, ar, ac, 1'b1);
    endfunction

    function void note_request(logic kind, logic [47:0] d);
      if (kind == glos_pkg::REQ_WRITE) begin
        wall_map[d[5:0]][d[13:6]] = d[14];
      end else begin
        clear_answers.push_back(line_is_clear(int'(d[20:15]), int'(d[28:21]),
                                              int'(d[34:29]), int'(d[42:35])));
      end
    endfunction

    function void check_answer(logic [7:0] d);
      bit want;
      if (clear_answers.size() == 0) begin
        $error("line_clear: result with no query waiting, expected none, actual %0d", d[0]);
        failures++;
        return;
      end
      want = clear_answers.pop_front();
      if (d[0] !== want) begin
        $error("line_clear: expected %0d, actual %0d", want, d[0]);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  int send_idle;
  int recv_idle;
  int holds_asked;
  int holds_done = 0;
  int hold_left = 0;

  los_tracker tracker = new();

  grid_line_of_sight_trace_core #(
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      m_tready   <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_asked;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_answer(m_tdata);
      if (s_tvalid && s_tready) tracker.note_request(s_tuser, s_tdata);
    end
  end

  function automatic logic [47:0] pack_fields(int mr, int mc, int mb, int sr, int sc,
                                              int er, int ec);
    return {5'b0, ec[7:0], er[5:0], sc[7:0], sr[5:0], mb[0], mc[7:0], mr[5:0]};
  endfunction

  task automatic send_request(input logic kind, input logic [47:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_cell(input int r, input int c, input int b);
    send_request(glos_pkg::REQ_WRITE,
                 pack_fields(r, c, b, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic query_line(input int r1, input int c1, input int r2, input int c2);
    send_request(glos_pkg::REQ_QUERY,
                 pack_fields($urandom, $urandom, $urandom, r1, c1, r2, c2));
  endtask

  // Most items stay inside a small window around (r0, c0) so that walls and lines meet.
  task automatic random_request(input int r0, input int c0);
    int pick;
    int r1;
    int c1;
    int r2;
    int c2;
    pick = $urandom_range(99);
    r1 = r0 + $urandom_range(11);
    c1 = c0 + $urandom_range(23);
    r2 = r0 + $urandom_range(11);
    c2 = c0 + $urandom_range(23);
    if (pick < 30) begin
      write_cell(r1, c1, $urandom_range(99) < 35);
    end else if (pick < 35) begin
      write_cell($urandom_range(63), $urandom_range(255), $urandom_range(1));
    end else if (pick < 42) begin
      query_line($urandom_range(63), $urandom_range(255), $urandom_range(63),
                 $urandom_range(255));
    end else if (pick < 52) begin
      if ($urandom_range(1)) query_line(r1, c1, r1, c2);
      else query_line(r1, c1, r2, c1);
    end else if (pick < 62) begin
      if ($urandom_range(1))
        query_line(r1, c1, r1 + ($urandom_range(1) ? 1 : -1) * (1 + $urandom_range(1)),
                   c1 + ($urandom_range(1) ? 2 : -2));
      else
        query_line(r1, c1, r1 + ($urandom_range(1) ? 2 : -2),
                   c1 + ($urandom_range(1) ? 1 : -1) * (1 + $urandom_range(1)));
    end else if (pick < 68) begin
      pick = $urandom_range(1, 8);
      query_line(r1, c1, r1 + ($urandom_range(1) ? pick : -pick),
                 c1 + ($urandom_range(1) ? pick : -pick));
    end else begin
      query_line(r1, c1, r2, c2);
    end
  endtask

  initial begin
    int r0;
    int c0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = glos_pkg::REQ_WRITE;
    m_tready    = 1'b0;
    send_idle   = 20;
    recv_idle   = 20;
    holds_asked = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Equal and adjacent endpoints, straight lines and a blocked start cell.
    query_line(0, 0, 0, 0);
    query_line(5, 5, 6, 6);
    write_cell(10, 21, 1);
    query_line(10, 20, 10, 23);
    query_line(10, 23, 10, 20);
    query_line(10, 21, 10, 25);
    write_cell(12, 20, 1);
    query_line(10, 20, 14, 20);
    // Knight steps along columns and along rows.
    query_line(20, 30, 21, 32);
    write_cell(20, 31, 1);
    query_line(20, 30, 21, 32);
    write_cell(31, 40, 1);
    query_line(30, 40, 32, 41);
    // Exact corners step diagonally without looking at the side cell.
    write_cell(41, 10, 1);
    query_line(40, 10, 43, 13);
    write_cell(41, 11, 1);
    query_line(40, 10, 41, 13);
    // A corner passed off the exact point checks the side cell.
    write_cell(51, 1, 1);
    query_line(50, 0, 52, 5);
    // Extremes of the map, both directions, then a cleared wall.
    write_cell(63, 255, 1);
    query_line(0, 0, 63, 255);
    query_line(63, 255, 0, 0);
    write_cell(63, 255, 0);
    write_cell(51, 1, 0);
    query_line(50, 0, 52, 5);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 31;
          recv_idle = 52;
        end
        1: begin
          send_idle = 52;
          recv_idle = 31;
        end
        default: begin
          send_idle   = 0;
          recv_idle   = 0;
          holds_asked = holds_asked + 1;
        end
      endcase
      r0 = $urandom_range(63);
      c0 = $urandom_range(255);
      repeat (175) random_request(r0, c0);
    end
    s_tvalid <= 1'b0;

    while (tracker.clear_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.clear_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
